// ----- design/wrms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the weighted running mean / mean-of-squares block.
// Used by wrms_ctrl, wrms_dp and weighted_running_mean_and_square.
package wrms_pkg;

    localparam int COORD_W   = 32;              // signed Q16.16 coordinate
    localparam int WEIGHT_W  = 16;              // point weight
    localparam int SQ_W      = 64;              // unsigned Q32.32 mean of squares
    localparam int TOTW_W    = 32;              // saturating total weight
    localparam int SUMW_W    = TOTW_W + 1;      // unsaturated divisor W + w
    localparam int PROD_W    = 2 * COORD_W;     // one pass of the shared multiplier
    localparam int P2_W      = COORD_W + WEIGHT_W;
    // square numerator is below 2^97; rounded up to an even count for radix-4 steps
    localparam int NUM_W     = 98;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int MUL_STEPS = 7;

    // operand pair on the shared multiplier; the same code, registered with the
    // product, says where the registered product goes
    typedef enum logic [3:0] {
        MS_NONE,
        MS_CSQ,     // |c| * |c|
        MS_P1,      // |old mean| * W
        MS_P2,      // |c| * w
        MS_SQLO,    // old square low half * W
        MS_SQHI,    // old square high half * W
        MS_CLO,     // |c|^2 low half * w
        MS_CHI,     // |c|^2 high half * w
        MS_NULL     // |new mean| * |new mean|
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     rd;
        t_mul_sel mul_sel;
        logic     form;
        logic     div_step;
        logic     fin;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic attach;
        logic sum_zero;
    } t_dp_status;

endpackage

// ----- design/wrms_dp.sv -----
`timescale 1ns / 1ps
// Datapath: coordinate stores, shared 32x32 multiplier, radix-4 dual divider,
// running weight / index state and the output word register. Uses wrms_pkg.
module wrms_dp #(
    parameter int MAX_DIMS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wrms_pkg::t_dp_cmd                   i_ctl,
    output wrms_pkg::t_dp_status                o_status,
    input  logic                                i_cmd,
    input  logic signed [wrms_pkg::COORD_W-1:0] i_coord,
    input  logic [wrms_pkg::WEIGHT_W-1:0]       i_weight,
    input  logic                                i_last,
    output logic signed [wrms_pkg::COORD_W-1:0] o_mean,
    output logic [wrms_pkg::SQ_W-1:0]           o_mean_square,
    output logic                                o_null_sigma,
    output logic                                o_any_null_sigma,
    output logic                                o_last_out
);
    import wrms_pkg::*;

    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIMS - 1);

    typedef struct packed {
        logic [NUM_W-1:0]  n;   // dividend shifting out, quotient shifting in
        logic [SUMW_W-1:0] r;
    } t_div_st;

    function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // two restoring steps; remainder stays below d
    function automatic t_div_st div2(input t_div_st s, input logic [SUMW_W-1:0] d);
        logic [SUMW_W:0]   t1;
        logic [SUMW_W:0]   t2;
        logic [SUMW_W-1:0] r1;
        logic              ge1;
        logic              ge2;
        t_div_st           o;
        t1  = {s.r, s.n[NUM_W-1]};
        ge1 = (t1 >= {1'b0, d});
        r1  = ge1 ? SUMW_W'(t1 - {1'b0, d}) : SUMW_W'(t1);
        t2  = {r1, s.n[NUM_W-2]};
        ge2 = (t2 >= {1'b0, d});
        o.r = ge2 ? SUMW_W'(t2 - {1'b0, d}) : SUMW_W'(t2);
        o.n = {s.n[NUM_W-3:0], ge1, ge2};
        return o;
    endfunction

    // stores: contents undefined until a start word writes them
    logic [COORD_W-1:0] r_mean_mem [MAX_DIMS];
    logic [SQ_W-1:0]    r_sq_mem   [MAX_DIMS];

    // captured word
    logic                r_cmd;
    logic [COORD_W-1:0]  r_coord;
    logic [COORD_W-1:0]  r_cmag;
    logic [WEIGHT_W-1:0] r_w;
    logic                r_last;
    logic [SUMW_W-1:0]   r_sumw;

    // running state
    logic [TOTW_W-1:0]   r_tot_w;
    logic [IDX_W-1:0]    r_coord_idx;
    logic                r_null_seen;

    logic [COORD_W-1:0]  r_old_mean;
    logic [SQ_W-1:0]     r_old_sq;

    logic [PROD_W-1:0]   r_prod;
    t_mul_sel            r_acc_sel;
    logic [SQ_W-1:0]     r_csq;
    logic [PROD_W-1:0]   r_p1;
    logic [P2_W-1:0]     r_p2;

    logic [NUM_W-1:0]    r_n1;
    logic [NUM_W-1:0]    r_n2;
    logic [SUMW_W-1:0]   r_r1;
    logic [SUMW_W-1:0]   r_r2;
    logic                r_neg;

    logic [COORD_W-1:0]  r_mean_new;
    logic [SQ_W-1:0]     r_sq_new;

    logic [COORD_W-1:0]  r_out_mean;
    logic [SQ_W-1:0]     r_out_sq;
    logic                r_out_null;
    logic                r_out_any;
    logic                r_out_last;

    logic [COORD_W-1:0]  mul_a;
    logic [COORD_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W:0]     f_sum;
    logic [PROD_W:0]     f_d12;
    logic [PROD_W:0]     f_d21;
    logic [PROD_W:0]     f_mag;
    logic                f_neg;
    logic                old_neg;
    logic [COORD_W-1:0]  q_mean;
    logic [COORD_W-1:0]  fin_mean;
    logic [SQ_W-1:0]     fin_sq;
    logic                null_now;
    logic                any_now;
    t_div_st             d1_next;
    t_div_st             d2_next;

    assign o_status.attach   = r_cmd;
    assign o_status.sum_zero = (r_sumw == '0);

    // shared multiplier operand select
    always_comb begin
        unique case (i_ctl.mul_sel)
            MS_CSQ:  begin mul_a = r_cmag;                mul_b = r_cmag; end
            MS_P1:   begin mul_a = mag(r_old_mean);       mul_b = r_tot_w; end
            MS_P2:   begin mul_a = r_cmag;                mul_b = COORD_W'(r_w); end
            MS_SQLO: begin mul_a = r_old_sq[31:0];        mul_b = r_tot_w; end
            MS_SQHI: begin mul_a = r_old_sq[63:32];       mul_b = r_tot_w; end
            MS_CLO:  begin mul_a = r_csq[31:0];           mul_b = COORD_W'(r_w); end
            MS_CHI:  begin mul_a = r_csq[63:32];          mul_b = COORD_W'(r_w); end
            MS_NULL: begin mul_a = mag(r_mean_new);       mul_b = mag(r_mean_new); end
            default: begin mul_a = '0;                    mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // signed combine of W*old and w*new as sign and magnitude
    assign old_neg = r_old_mean[COORD_W-1];
    always_comb begin
        f_sum = {1'b0, r_p1} + {{(PROD_W + 1 - P2_W){1'b0}}, r_p2};
        f_d12 = {1'b0, r_p1} - {{(PROD_W + 1 - P2_W){1'b0}}, r_p2};
        f_d21 = {{(PROD_W + 1 - P2_W){1'b0}}, r_p2} - {1'b0, r_p1};
        if (old_neg == r_coord[COORD_W-1]) begin
            f_mag = f_sum;
            f_neg = old_neg;
        end else if (!f_d12[PROD_W]) begin
            f_mag = f_d12;
            f_neg = old_neg;
        end else begin
            f_mag = f_d21;
            f_neg = r_coord[COORD_W-1];
        end
    end

    assign d1_next = div2('{n: r_n1, r: r_r1}, r_sumw);
    assign d2_next = div2('{n: r_n2, r: r_r2}, r_sumw);

    assign q_mean = r_neg ? (~r_n1[COORD_W-1:0] + 1'b1) : r_n1[COORD_W-1:0];

    always_comb begin
        priority if (!r_cmd) begin
            fin_mean = r_coord;
            fin_sq   = r_csq;
        end else if (r_sumw == '0) begin
            fin_mean = r_old_mean;
            fin_sq   = r_old_sq;
        end else begin
            fin_mean = q_mean;
            fin_sq   = r_n2[SQ_W-1:0];
        end
    end

    assign null_now = (r_prod == r_sq_new);
    assign any_now  = r_null_seen | null_now;

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_mean_mem[r_coord_idx] <= fin_mean;
            r_sq_mem[r_coord_idx]   <= fin_sq;
        end
        if (i_ctl.rd) begin
            r_old_mean <= r_mean_mem[r_coord_idx];
            r_old_sq   <= r_sq_mem[r_coord_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_coord <= i_coord;
            r_cmag  <= mag(i_coord);
            r_w     <= i_weight;
            r_last  <= i_last;
            r_sumw  <= SUMW_W'(r_tot_w) + SUMW_W'(i_weight);
        end

        if (i_ctl.mul_sel != MS_NONE) begin
            r_prod <= mul_p;
        end
        r_acc_sel <= i_ctl.mul_sel;

        if (i_ctl.div_step) begin
            r_n1 <= d1_next.n;
            r_r1 <= d1_next.r;
            r_n2 <= d2_next.n;
            r_r2 <= d2_next.r;
        end else if (i_ctl.form) begin
            r_n1  <= NUM_W'(f_mag);
            r_neg <= f_neg;
            r_r1  <= '0;
            r_r2  <= '0;
        end else begin
            unique case (r_acc_sel)
                MS_CSQ:  r_csq <= r_prod;
                MS_P1:   r_p1  <= r_prod;
                MS_P2:   r_p2  <= r_prod[P2_W-1:0];
                MS_SQLO: r_n2  <= NUM_W'(r_prod);
                MS_SQHI: r_n2  <= r_n2 + {2'b00, r_prod, 32'h0};
                MS_CLO:  r_n2  <= r_n2 + NUM_W'(r_prod);
                MS_CHI:  r_n2  <= r_n2 + {2'b00, r_prod, 32'h0};
                default: ;
            endcase
        end

        if (i_ctl.fin) begin
            r_mean_new <= fin_mean;
            r_sq_new   <= fin_sq;
        end

        if (i_ctl.commit) begin
            r_out_mean <= r_mean_new;
            r_out_sq   <= r_sq_new;
            r_out_null <= null_now;
            r_out_any  <= any_now;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_w     <= '0;
            r_coord_idx <= '0;
            r_null_seen <= 1'b0;
        end else if (i_ctl.commit) begin
            if (r_last) begin
                if (!r_cmd) begin
                    r_tot_w <= TOTW_W'(r_w);
                end else begin
                    r_tot_w <= r_sumw[TOTW_W] ? '1 : r_sumw[TOTW_W-1:0];
                end
                r_coord_idx <= '0;
                r_null_seen <= 1'b0;
            end else begin
                r_coord_idx <= (r_coord_idx == IDX_LAST) ? '0 : r_coord_idx + 1'b1;
                r_null_seen <= any_now;
            end
        end
    end

    assign o_mean           = r_out_mean;
    assign o_mean_square    = r_out_sq;
    assign o_null_sigma     = r_out_null;
    assign o_any_null_sigma = r_out_any;
    assign o_last_out       = r_out_last;

endmodule

// ----- design/wrms_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences one word through read, multiply passes, division,
// store write-back and output handoff. Uses wrms_pkg command/status types.
module wrms_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  wrms_pkg::t_dp_status i_status,
    output wrms_pkg::t_dp_cmd    o_ctl
);
    import wrms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DRAIN,
        S_FORM,
        S_DIV,
        S_FIN,
        S_NMUL,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_valid;
    logic             accept;
    logic             out_free;
    t_mul_sel         seq_sel;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;

    always_comb begin
        unique case (r_cnt[2:0])
            3'd0:    seq_sel = MS_CSQ;
            3'd1:    seq_sel = MS_P1;
            3'd2:    seq_sel = MS_P2;
            3'd3:    seq_sel = MS_SQLO;
            3'd4:    seq_sel = MS_SQHI;
            3'd5:    seq_sel = MS_CLO;
            3'd6:    seq_sel = MS_CHI;
            default: seq_sel = MS_NONE;
        endcase
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.mul_sel = MS_NONE;
        unique case (r_state)
            S_IDLE:  o_ctl.load     = accept;
            S_READ:  o_ctl.rd       = 1'b1;
            S_MUL:   o_ctl.mul_sel  = seq_sel;
            S_FORM:  o_ctl.form     = 1'b1;
            S_DIV:   o_ctl.div_step = 1'b1;
            S_FIN:   o_ctl.fin      = 1'b1;
            S_NMUL:  o_ctl.mul_sel  = MS_NULL;
            S_OUT:   o_ctl.commit   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_ctl.commit) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_cnt <= '0;
                    // attach with zero combined weight keeps the stored pair
                    if (i_status.attach && i_status.sum_zero) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!i_status.attach || r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: r_state <= i_status.attach ? S_FORM : S_FIN;
                S_FORM: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN:  r_state <= S_NMUL;
                S_NMUL: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.commit |-> !(r_valid && i_stall))
        else $error("result committed over a stalled word");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.commit |=> r_valid)
        else $error("committed result not presented");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(DIV_STEPS - 1)))
        else $error("divider step count overrun");

    a_zero_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && i_status.attach && i_status.sum_zero) |=> (r_state == S_FIN))
        else $error("zero-weight attach entered arithmetic");

    a_load_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_READ && o_stall))
        else $error("accepted word not started");

endmodule

// ----- design/weighted_running_mean_and_square.sv -----
`timescale 1ns / 1ps
// Weighted running mean and mean of squares per coordinate of a cluster center.
// Input channel: i_valid / o_stall with i_cmd, i_coord, i_weight, i_last; a word
//   is taken on a rising edge with i_valid high and o_stall low. One input word
//   carries one coordinate; i_last marks the final coordinate of a point.
// Output channel: o_valid / i_stall with o_mean, o_mean_square, o_null_sigma,
//   o_any_null_sigma, o_last_out; exactly one result word per input word.
// Sequence: an attach word takes 7 passes of one shared 32x32 multiplier, then
//   49 radix-4 steps of the divider that forms both quotients by W + w at once,
//   then the null-check pass. A start word makes only the |c|^2 pass and the
//   null-check pass; an attach with zero combined weight skips the arithmetic.
//   The next word is taken only after a result is registered, so the block does
//   not take a new word before it is through with the last one.
// The output register holds its word while i_stall is high; the block meanwhile
//   takes and computes the next word, and waits only to hand that one over.
// Reset (i_rst_n low, synchronous) clears total weight, coordinate index and
//   the running zero-variance flag and drops o_valid. The coordinate stores
//   are not cleared: a start word must write an entry before it is attached to.
module weighted_running_mean_and_square #(
    parameter int MAX_DIMS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic signed [wrms_pkg::COORD_W-1:0] i_coord,
    input  logic [wrms_pkg::WEIGHT_W-1:0]       i_weight,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [wrms_pkg::COORD_W-1:0] o_mean,
    output logic [wrms_pkg::SQ_W-1:0]           o_mean_square,
    output logic                                o_null_sigma,
    output logic                                o_any_null_sigma,
    output logic                                o_last_out
);
    import wrms_pkg::*;

    t_dp_cmd    ctl;
    t_dp_status status;

    wrms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_ctl    (ctl)
    );

    wrms_dp #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_status         (status),
        .i_cmd            (i_cmd),
        .i_coord          (i_coord),
        .i_weight         (i_weight),
        .i_last           (i_last),
        .o_mean           (o_mean),
        .o_mean_square    (o_mean_square),
        .o_null_sigma     (o_null_sigma),
        .o_any_null_sigma (o_any_null_sigma),
        .o_last_out       (o_last_out)
    );

endmodule

// ----- sim/tb_weighted_running_mean_and_square.sv -----
`timescale 1ns / 1ps
// Testbench for weighted_running_mean_and_square: a directed table, then random points.
// Every result word is checked against a behavioral model of the cluster center, or against the table for typed rows.
// Depends on wrms_pkg and the design top level.
module tb_weighted_running_mean_and_square;
    import wrms_pkg::*;

    localparam int MAX_DIMS     = 8;
    localparam bit CMD_START    = 1'b0;
    localparam bit CMD_ATTACH   = 1'b1;
    localparam int N_RANDOM     = 450;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [COORD_W-1:0] mean;
        logic [SQ_W-1:0]    mean_square;
        logic               null_sigma;
        logic               any_null;
        logic               last_out;
    } t_result;

    typedef struct packed {
        logic                cmd;
        logic [COORD_W-1:0]  coord;
        logic [WEIGHT_W-1:0] weight;
        logic                lst;
        logic                typed;     // want below is used instead of the model
        t_result             want;
    } t_row;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic                 i_cmd    = 1'b0;
    logic [COORD_W-1:0]   i_coord  = '0;
    logic [WEIGHT_W-1:0]  i_weight = '0;
    logic                 i_last   = 1'b0;
    logic                 i_stall  = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [COORD_W-1:0]   o_mean;
    logic [SQ_W-1:0]      o_mean_square;
    logic                 o_null_sigma;
    logic                 o_any_null_sigma;
    logic                 o_last_out;

    // model copy of the center
    logic [COORD_W-1:0]   ctr_mean    [MAX_DIMS];
    logic [SQ_W-1:0]      ctr_square  [MAX_DIMS];
    bit                   ctr_written [MAX_DIMS];
    logic [TOTW_W-1:0]    ctr_weight = '0;
    int                   ctr_idx    = 0;
    logic                 ctr_null   = 1'b0;

    t_result pending_results [$];
    t_row    dir_rows [$];
    int      errors      = 0;
    int      idle_cycles = 0;
    int      rx_hold     = 0;

    weighted_running_mean_and_square #(
        .MAX_DIMS(MAX_DIMS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_coord          (i_coord),
        .i_weight         (i_weight),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mean           (o_mean),
        .o_mean_square    (o_mean_square),
        .o_null_sigma     (o_null_sigma),
        .o_any_null_sigma (o_any_null_sigma),
        .o_last_out       (o_last_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] abs_q16(input logic [31:0] v);
        return v[31] ? {32'd0, ~v + 32'd1} : {32'd0, v};
    endfunction

    // one coordinate word through the center update; returns the expected word
    function automatic t_result center_update(input logic cmd, input logic [31:0] c,
                                              input logic [15:0] w, input logic lst);
        int           k;
        logic [63:0]  cmag, omag, mmag, csq, p1, p2, mag, q, tw, wv, sw;
        logic [127:0] num, quot;
        logic         cneg, oneg, neg;
        t_result      r;
        k    = ctr_idx;
        cneg = c[31];
        cmag = abs_q16(c);
        csq  = cmag * cmag;
        tw   = {32'd0, ctr_weight};
        wv   = {48'd0, w};
        sw   = tw + wv;
        if (cmd == CMD_START) begin
            ctr_mean[k]    = c;
            ctr_square[k]  = csq;
            ctr_written[k] = 1'b1;
        end else if (sw != 64'd0) begin
            oneg = ctr_mean[k][31];
            omag = abs_q16(ctr_mean[k]);
            p1   = omag * tw;
            p2   = cmag * wv;
            if (oneg == cneg) begin
                mag = p1 + p2;
                neg = oneg;
            end else if (p1 >= p2) begin
                mag = p1 - p2;
                neg = oneg;
            end else begin
                mag = p2 - p1;
                neg = cneg;
            end
            q = mag / sw;
            ctr_mean[k] = neg ? ~q[31:0] + 32'd1 : q[31:0];
            // numerator is below 2^97, divisor is the unsaturated W + w
            num  = {64'd0, ctr_square[k]} * {96'd0, ctr_weight} + {64'd0, csq} * {112'd0, w};
            quot = num / {64'd0, sw};
            ctr_square[k] = quot[63:0];
        end
        mmag          = abs_q16(ctr_mean[k]);
        r.mean        = ctr_mean[k];
        r.mean_square = ctr_square[k];
        r.null_sigma  = (ctr_square[k] == mmag * mmag);
        r.any_null    = ctr_null | r.null_sigma;
        r.last_out    = lst;
        if (lst) begin
            if (cmd == CMD_START)
                ctr_weight = {16'd0, w};
            else
                ctr_weight = (sw[63:32] != 32'd0) ? 32'hFFFF_FFFF : sw[31:0];
            ctr_idx  = 0;
            ctr_null = 1'b0;
        end else begin
            ctr_idx  = (k + 1 >= MAX_DIMS) ? 0 : k + 1;
            ctr_null = r.any_null;
        end
        return r;
    endfunction

    function automatic t_row mk_row(input logic cmd, input logic [31:0] coord,
                                    input logic [15:0] weight, input logic lst,
                                    input logic typed, input logic [31:0] mean,
                                    input logic [63:0] msq, input logic nul,
                                    input logic any_nul);
        t_row r;
        r.cmd    = cmd;
        r.coord  = coord;
        r.weight = weight;
        r.lst    = lst;
        r.typed  = typed;
        r.want   = '{mean, msq, nul, any_nul, lst};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_word(input int gap, input logic cmd, input logic [31:0] coord,
                             input logic [15:0] weight, input logic lst,
                             input logic typed, input t_result want);
        t_result pred;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pred = center_update(cmd, coord, weight, lst);
        pending_results.push_back(typed ? want : pred);
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_coord  <= coord;
        i_weight <= weight;
        i_last   <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // sender holds off until every pending word has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // output side: random stall pattern, with long quiet stretches
    always @(posedge i_clk) begin : rx_side
        int sel;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                i_stall <= 1'b0;
                rx_hold <= $urandom_range(0, 6);
            end else if (sel < 90) begin
                i_stall <= 1'b1;
                rx_hold <= $urandom_range(0, 3);
            end else if (sel < 97) begin
                i_stall <= 1'b0;
                rx_hold <= $urandom_range(100, 400);
            end else begin
                i_stall <= 1'b1;
                rx_hold <= $urandom_range(20, 120);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with nothing pending", o_mean_square, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_mean !== want.mean)
                        report_mismatch("mean", 64'(o_mean), 64'(want.mean));
                    if (o_mean_square !== want.mean_square)
                        report_mismatch("mean_square", o_mean_square, want.mean_square);
                    if (o_null_sigma !== want.null_sigma)
                        report_mismatch("null_sigma", 64'(o_null_sigma),
                                        64'(want.null_sigma));
                    if (o_any_null_sigma !== want.any_null)
                        report_mismatch("any_null_sigma", 64'(o_any_null_sigma),
                                        64'(want.any_null));
                    if (o_last_out !== want.last_out)
                        report_mismatch("last_out", 64'(o_last_out), 64'(want.last_out));
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          sent, kind, dims, sel, gap, d;
        bit          quiet;
        logic        cmd, lst;
        logic [31:0] coord;
        logic [15:0] wt;

        // directed: after reset, extremes, zero combined weight, wrap, mixed commands
        //                     cmd         coord         wt        lst   typed  mean
        //                     mean_square             null any
        dir_rows.push_back(mk_row(CMD_START,  32'h0000_0000, 16'h0000, 1'b0, 1'b1, 32'h0000_0000,
                                  64'h0000_0000_0000_0000, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_START,  32'h7FFF_FFFF, 16'h0000, 1'b0, 1'b1, 32'h7FFF_FFFF,
                                  64'h3FFF_FFFF_0000_0001, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_START,  32'h8000_0000, 16'h0000, 1'b1, 1'b1, 32'h8000_0000,
                                  64'h4000_0000_0000_0000, 1'b1, 1'b1));
        // W + w is zero: stored pairs come back untouched
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h1234_5678, 16'h0000, 1'b0, 1'b1, 32'h0000_0000,
                                  64'h0000_0000_0000_0000, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'hDEAD_BEEF, 16'h0000, 1'b0, 1'b1, 32'h7FFF_FFFF,
                                  64'h3FFF_FFFF_0000_0001, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h7FFF_FFFF, 16'h0000, 1'b1, 1'b1, 32'h8000_0000,
                                  64'h4000_0000_0000_0000, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_START,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 32'hFFFF_FFFF,
                                  64'h0000_0000_0000_0001, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_START,  32'h0001_0000, 16'hFFFF, 1'b1, 1'b1, 32'h0001_0000,
                                  64'h0000_0001_0000_0000, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h0001_0000, 16'h0001, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h8000_0001, 16'h0000, 1'b1, 1'b0, '0, '0, 0, 0));
        // eight words without a last mark, so the ninth wraps back to index zero
        dir_rows.push_back(mk_row(CMD_START,  32'h0000_0001, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'hFFFE_8000, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'h0003_4000, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'h5555_5555, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'hAAAA_AAAA, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'h0000_8000, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'hC000_0000, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'h7FFF_0000, 16'h0003, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'hFFFF_0000, 16'h0005, 1'b1, 1'b0, '0, '0, 0, 0));
        // mixed commands: the final word's cmd sets the total weight
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h0002_0000, 16'h0007, 1'b0, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_START,  32'hFFFD_0000, 16'h0009, 1'b1, 1'b0, '0, '0, 0, 0));
        dir_rows.push_back(mk_row(CMD_ATTACH, 32'h0010_0000, 16'hFFFF, 1'b1, 1'b0, '0, '0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n])
            send_word($urandom_range(0, 2), dir_rows[n].cmd, dir_rows[n].coord,
                      dir_rows[n].weight, dir_rows[n].lst, dir_rows[n].typed, dir_rows[n].want);
        wait_drained();

        // random points: mostly well-formed, some mixed and some broken
        sent = 0;
        while (sent < N_RANDOM) begin
            kind  = $urandom_range(0, 99);
            dims  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_DIMS)
                                                : $urandom_range(1, 4);
            if (kind >= 92)
                dims = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 4);
            quiet = ($urandom_range(0, 9) < 3);
            sel   = $urandom_range(0, 99);
            wt    = (sel < 10) ? 16'h0000 :
                    (sel < 20) ? 16'hFFFF :
                    (sel < 50) ? 16'($urandom_range(1, 16)) : 16'($urandom_range(0, 65535));
            for (d = 0; d < dims; d++) begin
                if (kind < 30)
                    cmd = CMD_START;
                else if (kind < 80)
                    cmd = CMD_ATTACH;
                else
                    cmd = 1'($urandom_range(0, 1));
                // never attach to an entry that no start has written
                if (cmd == CMD_ATTACH && !ctr_written[ctr_idx])
                    cmd = CMD_START;
                lst = (d == dims - 1);
                if (kind >= 92) begin
                    lst = lst & 1'($urandom_range(0, 1));
                    wt  = 16'($urandom_range(0, 65535));
                end
                sel   = $urandom_range(0, 99);
                coord = (sel < 10) ? 32'h7FFF_FFFF :
                        (sel < 20) ? 32'h8000_0000 :
                        (sel < 27) ? 32'h0000_0000 :
                        (sel < 34) ? 32'hFFFF_FFFF :
                        (sel < 40) ? 32'h0000_0001 :
                        (sel < 70) ? 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000 :
                                     32'($urandom);
                sel = $urandom_range(0, 99);
                gap = quiet      ? 0 :
                      (sel < 65) ? 0 :
                      (sel < 93) ? $urandom_range(1, 4) : $urandom_range(20, 90);
                send_word(gap, cmd, coord, wt, lst, 1'b0, '0);
                sent++;
                if (sent % 150 == 0)
                    wait_drained();
            end
        end

        wait_drained();
        // catch any stray word after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/wrms_pkg.sv
design/wrms_dp.sv
design/wrms_ctrl.sv
design/weighted_running_mean_and_square.sv
sim/tb_weighted_running_mean_and_square.sv
